/* design/mtwg_pkg.sv */
// Shared constants, types and tempering function for the MT19937 word generator.
package mtwg_pkg;

  localparam int unsigned N_WORDS = 624;
  localparam int unsigned M_OFFSET = 397;
  localparam int unsigned IDX_W = $clog2(N_WORDS);
  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] INIT_MULT = 32'h6C07_8965;
  localparam logic [WORD_W-1:0] MATRIX_A = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] RESET_SEED = 32'hDEAD_B08F;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_WORDS - 1);
  localparam logic [IDX_W:0] N_WIDE = (IDX_W + 1)'(N_WORDS);
  localparam logic [IDX_W:0] M_WIDE = (IDX_W + 1)'(M_OFFSET);

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Controller to datapath
  typedef struct packed {
    logic fill_init;   // write word 0 from seed, start fill
    logic use_in_seed; // seed from input word, else the reset seed
    logic fill_mul;    // multiply step of the seeding recurrence
    logic fill_wr;     // add index and write one seeded word
    logic twist_pre;   // read word 0, clear counter
    logic twist_ld;    // latch word 0 as the current word
    logic twist_rd;    // read next and far words
    logic twist_wr;    // write one twisted word
    logic draw_out;    // temper, load output register, advance index
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic idx_zero;
    logic out_full;
  } status_t;

  function automatic word_t temper(input word_t x);
    word_t y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* design/mtwg_in_if.sv */
// Input channel: op code and seed word with valid/ready handshake.
interface mtwg_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [31:0] seed_value;

  modport source(output valid, output op, output seed_value, input ready);
  modport sink(input valid, input op, input seed_value, output ready);
endinterface

/* design/mtwg_out_if.sv */
// Output channel: tempered random word with valid/ready handshake.
interface mtwg_out_if;
  logic valid;
  logic ready;
  logic [31:0] random_word;

  modport source(output valid, output random_word, input ready);
  modport sink(input valid, input random_word, output ready);
endinterface

/* design/mtwg_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module mtwg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* design/mtwg_ctrl.sv */
// Sequencer for seeding, twisting and drawing words.
module mtwg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  mtwg_pkg::status_t status,
  output mtwg_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FMUL = 4'd2;
  localparam logic [3:0] S_FWR  = 4'd3;
  localparam logic [3:0] S_TPRE = 4'd4;
  localparam logic [3:0] S_TLD  = 4'd5;
  localparam logic [3:0] S_TRD  = 4'd6;
  localparam logic [3:0] S_TWR  = 4'd7;
  localparam logic [3:0] S_DRD  = 4'd8;
  localparam logic [3:0] S_DOUT = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.fill_init = 1'b1;
        state_nxt = S_FMUL;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == mtwg_pkg::OP_RESEED) begin
            cmd.fill_init = 1'b1;
            cmd.use_in_seed = 1'b1;
            state_nxt = S_FMUL;
          end else if (status.idx_zero) begin
            state_nxt = S_TPRE;
          end else begin
            state_nxt = S_DRD;
          end
        end
      end
      S_FMUL: begin
        cmd.fill_mul = 1'b1;
        state_nxt = S_FWR;
      end
      S_FWR: begin
        cmd.fill_wr = 1'b1;
        state_nxt = status.cnt_last ? S_IDLE : S_FMUL;
      end
      S_TPRE: begin
        cmd.twist_pre = 1'b1;
        state_nxt = S_TLD;
      end
      S_TLD: begin
        cmd.twist_ld = 1'b1;
        state_nxt = S_TRD;
      end
      S_TRD: begin
        cmd.twist_rd = 1'b1;
        state_nxt = S_TWR;
      end
      S_TWR: begin
        cmd.twist_wr = 1'b1;
        state_nxt = status.cnt_last ? S_DRD : S_TRD;
      end
      S_DRD: begin
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        // hold until the output register can take the word
        if (!status.out_full) begin
          cmd.draw_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

/* design/mtwg_dp.sv */
// Datapath: state store, seeding multiplier, twist and tempering, output register.
module mtwg_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mtwg_pkg::cmd_t      cmd,
  output mtwg_pkg::status_t   status,
  input  mtwg_pkg::word_t     seed_value,
  input  logic                out_ready,
  output logic                out_valid,
  output mtwg_pkg::word_t     out_word
);

  mtwg_pkg::idx_t  cnt_r, cnt_nxt;
  mtwg_pkg::idx_t  idx_r, idx_nxt;
  mtwg_pkg::word_t prev_r, prev_nxt;
  mtwg_pkg::word_t prod_r;
  mtwg_pkg::word_t out_word_r;
  logic            out_valid_r, out_valid_nxt;

  mtwg_pkg::word_t seed_src;
  mtwg_pkg::word_t mix;
  logic [2*mtwg_pkg::WORD_W-1:0] prod_full;
  mtwg_pkg::word_t fill_val;
  mtwg_pkg::word_t y;
  mtwg_pkg::word_t twist_val;
  mtwg_pkg::idx_t  nxt_addr;
  mtwg_pkg::idx_t  far_addr;
  logic [mtwg_pkg::IDX_W:0] far_sum;

  logic            we;
  mtwg_pkg::idx_t  waddr;
  mtwg_pkg::word_t wdata;
  mtwg_pkg::idx_t  raddr_a;
  mtwg_pkg::idx_t  raddr_b;
  mtwg_pkg::word_t rdata_a;
  mtwg_pkg::word_t rdata_b;

  assign seed_src = cmd.use_in_seed ? seed_value : mtwg_pkg::RESET_SEED;

  // seeding recurrence, low 32 bits of the product
  assign mix = prev_r ^ (prev_r >> 30);
  assign prod_full = mix * mtwg_pkg::INIT_MULT;
  assign fill_val = prod_r + mtwg_pkg::word_t'(cnt_r);

  assign nxt_addr = (cnt_r == mtwg_pkg::LAST_IDX) ? '0 : cnt_r + 1'b1;
  assign far_sum = {1'b0, cnt_r} + mtwg_pkg::M_WIDE;
  assign far_addr = (far_sum >= mtwg_pkg::N_WIDE) ?
                    far_sum[mtwg_pkg::IDX_W-1:0] - mtwg_pkg::N_WIDE[mtwg_pkg::IDX_W-1:0] :
                    far_sum[mtwg_pkg::IDX_W-1:0];

  // upper bit of the current word, lower 31 bits of the next
  assign y = {prev_r[mtwg_pkg::WORD_W-1], rdata_a[mtwg_pkg::WORD_W-2:0]};
  assign twist_val = rdata_b ^ (y >> 1) ^ (y[0] ? mtwg_pkg::MATRIX_A : '0);

  always_comb begin
    we = 1'b0;
    waddr = cnt_r;
    wdata = fill_val;
    if (cmd.fill_init) begin
      we = 1'b1;
      waddr = '0;
      wdata = seed_src;
    end else if (cmd.fill_wr) begin
      we = 1'b1;
    end else if (cmd.twist_wr) begin
      we = 1'b1;
      wdata = twist_val;
    end
  end

  always_comb begin
    raddr_a = idx_r;
    raddr_b = far_addr;
    if (cmd.twist_pre) begin
      raddr_a = '0;
    end else if (cmd.twist_rd) begin
      raddr_a = nxt_addr;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    prev_nxt = prev_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.fill_init) begin
      cnt_nxt = mtwg_pkg::idx_t'(1);
      idx_nxt = '0;
      prev_nxt = seed_src;
    end
    if (cmd.fill_wr) begin
      cnt_nxt = cnt_r + 1'b1;
      prev_nxt = fill_val;
    end
    if (cmd.twist_pre) begin
      cnt_nxt = '0;
    end
    if (cmd.twist_ld) begin
      prev_nxt = rdata_a;
    end
    if (cmd.twist_wr) begin
      cnt_nxt = cnt_r + 1'b1;
      prev_nxt = rdata_a;
    end
    if (cmd.draw_out) begin
      out_valid_nxt = 1'b1;
      idx_nxt = (idx_r == mtwg_pkg::LAST_IDX) ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    if (cmd.fill_mul) begin
      prod_r <= prod_full[mtwg_pkg::WORD_W-1:0];
    end
    if (cmd.draw_out) begin
      out_word_r <= mtwg_pkg::temper(rdata_a);
    end
  end

  mtwg_ram #(
    .WIDTH(mtwg_pkg::WORD_W),
    .DEPTH(mtwg_pkg::N_WORDS)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  assign status.cnt_last = (cnt_r == mtwg_pkg::LAST_IDX);
  assign status.idx_zero = (idx_r == '0);
  assign status.out_full = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

endmodule

/* design/mt19937_word_generator.sv */
// MT19937 32-bit word generator top level.
// Draw: the word at the read index is read, tempered and loaded into the output register; the
//   next draw is accepted while an earlier word still waits in the output register.
// A draw that finds the read index at zero first twists the store: one store read and
//   one write-back per word. Reseed: busy, no output.
// After reset the store is seeded with 0xDEADB08F, with input ready low.
module mt19937_word_generator (
  input  logic clk,
  input  logic rst_n,
  mtwg_in_if.sink    in_ch,
  mtwg_out_if.source out_ch
);

  mtwg_pkg::cmd_t    cmd;
  mtwg_pkg::status_t status;

  mtwg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_op   (in_ch.op),
    .in_ready(in_ch.ready),
    .status  (status),
    .cmd     (cmd)
  );

  mtwg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .seed_value(in_ch.seed_value),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_word  (out_ch.random_word)
  );

endmodule

/* tb/mt19937_word_generator_tb.sv */
// Self-checking testbench for the MT19937 word generator: directed table, then random traffic.
`timescale 1ns / 100ps

module mt19937_word_generator_tb;
  import mtwg_pkg::*;

  localparam word_t UPPER_BIT = 32'h8000_0000;
  localparam word_t LOWER_BITS = 32'h7FFF_FFFF;
  localparam int unsigned HOLD_CYCLES = 1600;
  localparam int unsigned DRAIN_CYCLES = 1300;
  localparam int unsigned TARGET_ITEMS = 1250;

  typedef struct packed {
    logic  op;
    word_t seed;
    logic  known;
    word_t word;
  } stim_row_t;

  // Known words are the published first outputs for seed 5489.
  localparam stim_row_t DIRECTED [18] = '{
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{OP_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_DRAW,   32'd5489,      1'b0, 32'h0},
    '{OP_RESEED, 32'h0000_0000, 1'b0, 32'h0},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{OP_DRAW,   32'hA5A5_5A5A, 1'b0, 32'h0},
    '{OP_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{OP_RESEED, 32'd5489,      1'b0, 32'h0},
    '{OP_DRAW,   32'h0000_0000, 1'b1, 32'd3499211612},
    '{OP_DRAW,   32'hFFFF_FFFF, 1'b1, 32'd581869302},
    '{OP_DRAW,   32'h0000_0000, 1'b1, 32'd3890346734},
    '{OP_DRAW,   32'h1234_5678, 1'b1, 32'd3586334585},
    '{OP_DRAW,   32'h0000_0000, 1'b1, 32'd545404204},
    '{OP_RESEED, 32'h8000_0000, 1'b0, 32'h0},
    '{OP_RESEED, 32'h0000_0001, 1'b0, 32'h0},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0},
    '{OP_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  mtwg_in_if  in_ch ();
  mtwg_out_if out_ch ();

  mt19937_word_generator i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Generator mirror
  word_t       mt_store [N_WORDS];
  int unsigned mt_index;
  word_t       pending_words [$];
  int          fail_count;
  int          words_checked;
  int          burst_left;

  function automatic void seed_store(input word_t s);
    word_t p;
    mt_store[0] = s;
    for (int k = 1; k < N_WORDS; k++) begin
      p = mt_store[k-1];
      mt_store[k] = INIT_MULT * (p ^ (p >> 30)) + word_t'(k);
    end
    mt_index = 0;
  endfunction

  function automatic void regen_store();
    word_t y;
    word_t w;
    for (int unsigned k = 0; k < N_WORDS; k++) begin
      y = (mt_store[k] & UPPER_BIT) | (mt_store[(k + 1) % N_WORDS] & LOWER_BITS);
      w = mt_store[(k + M_OFFSET) % N_WORDS] ^ (y >> 1);
      if (y[0]) begin
        w = w ^ MATRIX_A;
      end
      mt_store[k] = w;
    end
  endfunction

  function automatic word_t temper_out(input word_t v);
    word_t t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic void advance_generator(input logic op, input word_t seed,
                                            output bit has_word, output word_t w);
    has_word = 1'b0;
    w = '0;
    if (op == OP_RESEED) begin
      seed_store(seed);
    end else begin
      if (mt_index >= N_WORDS) begin
        mt_index = 0;
      end
      if (mt_index == 0) begin
        regen_store();
      end
      w = temper_out(mt_store[mt_index]);
      mt_index = (mt_index + 1) % N_WORDS;
      has_word = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("ERROR @%0t: %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // Offer one item in bursts with random gaps; expectation is queued on accept.
  task automatic send_item(input logic op, input word_t seed, input logic known,
                           input word_t lit);
    int    gap;
    bit    has_word;
    word_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.seed_value <= seed;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    advance_generator(op, seed, has_word, w);
    if (has_word) begin
      pending_words.push_back(known ? lit : w);
    end
  endtask

  function automatic word_t pick_seed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Word checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with none expected", out_ch.random_word, '0);
      end else begin
        if (out_ch.random_word !== pending_words[0]) begin
          report_mismatch("random_word", out_ch.random_word, pending_words[0]);
        end
        void'(pending_words.pop_front());
      end
      words_checked++;
    end
  end

  // Receiver: random stall pattern, plus two long hold-offs so the input backs up
  initial begin
    int hold_mark;
    int on_len;
    int off_len;
    hold_mark = 120;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (words_checked >= hold_mark) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_mark = (hold_mark == 120) ? 900 : 32'h7FFF_FFFF;
      end
      on_len = $urandom_range(1, 40);
      out_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      off_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (off_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int    n_items;
    int    run_len;
    word_t seed;
    n_items = 0;
    fail_count = 0;
    words_checked = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_DRAW;
    in_ch.seed_value = '0;
    seed_store(RESET_SEED);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].op, DIRECTED[i].seed, DIRECTED[i].known, DIRECTED[i].word);
      n_items++;
    end

    // first run is long enough to wrap the read index
    run_len = $urandom_range(630, 700);
    while (n_items < TARGET_ITEMS) begin
      seed = pick_seed();
      send_item(OP_RESEED, seed, 1'b0, '0);
      n_items++;
      for (int k = 0; k < run_len; k++) begin
        send_item(OP_DRAW, $urandom, 1'b0, '0);
        n_items++;
      end
      run_len = $urandom_range(0, 60);
    end
    in_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("mt19937_word_generator regression: pass");
    end else begin
      $display("mt19937_word_generator regression: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #30_000_000;
    $display("mt19937_word_generator regression: fail");
    $finish;
  end

endmodule

/* files.f */
design/mtwg_pkg.sv
design/mtwg_in_if.sv
design/mtwg_out_if.sv
design/mtwg_ram.sv
design/mtwg_ctrl.sv
design/mtwg_dp.sv
design/mt19937_word_generator.sv
tb/mt19937_word_generator_tb.sv
